[src/tta_pkg.sv]
// Shared types and constants for the thermistor temperature averager.
// Holds the calibration table, status codes and the sequencer state type.
// No dependencies.
package tta_pkg;

   // Field and arithmetic widths
   localparam int CODE_W = 12;
   localparam int TEMP_W = 16;
   localparam int FRAC_BITS = 8;
   localparam int TOP_TEMP_C = 125;
   localparam int DIV_NUM_W = 56;
   localparam int DIV_DEN_W = 36;

   // Status codes
   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_HOT = 2'd1;
   localparam logic [1:0] STAT_COLD = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_REFERENCE = 2'd0;
   localparam logic [1:0] CSR_SUPPLY = 2'd1;
   localparam logic [1:0] CSR_TOP = 2'd2;

   // Calibration table: hundredths of an ohm, 125 C down to -55 C
   localparam int TABLE_ENTRIES = 181;
   localparam logic [26:0] CAL_ROM [0:TABLE_ENTRIES-1] = '{
      26006, 26755, 27528, 28327, 29153, 30007, 30891, 31806, 32752, 33730,
      34742, 35790, 36874, 37995, 39156, 40358, 41596, 42877, 44204, 45579,
      47003, 48479, 50008, 51594, 53237, 54941, 56719, 58564, 60478, 62463,
      64524, 66662, 68883, 71188, 73582, 76068, 78631, 81294, 84061, 86938,
      89928, 93037, 96270, 99634, 103130, 106770, 110600, 114580, 118730, 123050,
      127550, 132240, 137120, 142210, 147510, 153050, 158830, 164870, 171160,
      177730, 184590, 191750, 199220, 207030, 215180, 223700, 232590, 241890,
      251610, 261790, 272430, 283570, 295230, 307440, 320230, 333630, 347560,
      362150, 377440, 393470, 410260, 427880, 446350, 465720, 486060, 507400,
      530020, 553780, 578770, 605040, 632680, 661750, 692350, 724560, 758470,
      794200, 831220, 870190, 911230, 954460, 1000000,
      1048100, 1098800, 1152300, 1208800, 1268300, 1331300, 1397700, 1467900,
      1542000, 1620400, 1703300, 1791000, 1883800, 1982000, 2086000, 2196900,
      2314500, 2439200, 2571500, 2711900, 2860900, 3019200, 3187400, 3366200,
      3556300, 3758700, 3974000, 4203300, 4447500, 4707700, 4985000, 5280800,
      5596300, 5933100, 6292700, 6669700, 7072100, 7501700, 7960600, 8451000,
      8975200, 9535800, 10136000, 10778000, 11466000, 12190000, 12966000,
      13796000, 14686000, 15641000, 16664000, 17762000, 18941000, 20207000,
      21567000, 23015000, 24569000, 26236000, 28026000, 29947000, 32012000,
      34230000, 36615000, 39180000, 41938000, 44907000, 48102000, 51543000,
      55249000, 59243000, 63549000, 68191000, 73200000, 78604000, 84439000,
      90740000, 97547000, 104900000, 112860000, 121460000
   };

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_RDIV,
      S_RWAIT,
      S_RANGE,
      S_SEARCH,
      S_FDIV,
      S_FWAIT,
      S_WIN,
      S_FILL,
      S_UPD,
      S_MDIV,
      S_MWAIT,
      S_OUT
   } tta_state_type;

endpackage

[src/thermistor_temperature_averager.sv]
// Thermistor averager: each accepted word gives one result word after up to three passes
// through the shared serial divider (resistance, interpolation, mean) and a binary search
// of the calibration table; out-of-range samples skip some passes. One word at a time.
// The first word after reset also writes every window slot before the mean is formed.
// Synchronous active-high reset restores register defaults; window RAM is not cleared.
module thermistor_temperature_averager #(
   parameter int WINDOW_LENGTH = 60
) (
   input  logic        clock,
   input  logic        reset,
   // Input word
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] adc_code
   // Result word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] sample_temp, [31:16] mean_temp
   output logic [3:0]  rsp_tuser,   // [1:0] sample_status, [3:2] mean_status
   // Configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import tta_pkg::*;

   localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
   localparam int SUM_W = TEMP_W + $clog2(WINDOW_LENGTH) + 1;
   localparam int RAM_W = TEMP_W + 2;
   localparam int S_W = 43;
   localparam int E_W = 35;

   // Configuration registers
   logic [15:0] ref_ff, sup_ff;
   logic [19:0] top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= 16'd3300;
         sup_ff <= 16'd5000;
         top_ff <= 20'd10000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REFERENCE: ref_ff <= csr_wdata[15:0];
            CSR_SUPPLY:    sup_ff <= csr_wdata[15:0];
            CSR_TOP:       top_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Sequencer and datapath registers
   tta_state_type state_ff, state_in;
   logic [27:0]              mid_ff, mid_in;
   logic [47:0]              prod_ff, prod_in;
   logic [S_W-1:0]           s_ff, s_in;
   logic [7:0]               lo_ff, lo_in, hi_ff, hi_in;
   logic [1:0]               flag_ff, flag_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [SLOT_W-1:0]        fill_ff, fill_in, slot_ff, slot_in;
   logic [CNT_W-1:0]         hot_ff, hot_in, cold_ff, cold_in;
   logic                     primed_ff, primed_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [TEMP_W-1:0]        o_stemp_ff, o_stemp_in, o_mtemp_ff, o_mtemp_in;
   logic [1:0]               o_sstat_ff, o_sstat_in, o_mstat_ff, o_mstat_in;

   // Divider and RAM hookup
   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_q;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_waddr;
   logic [RAM_W-1:0]     ram_rdata;

   // Combinational helpers
   logic [27:0]             full;
   logic [8:0]              msum;
   logic [7:0]              midx, lo_next;
   logic [E_W-1:0]          e_mid, e_lo, e_hi, e_first, e_last;
   logic [S_W-1:0]          num_diff;
   logic [8:0]              deg;
   logic [1:0]              old_flag;
   logic signed [SUM_W-1:0] temp_ext, old_ext;
   logic [SUM_W-1:0]        abs_sum;
   logic [1:0]              mstat;

   assign full = {sup_ff, 12'd0};
   assign msum = 9'(lo_ff) + 9'(hi_ff);
   assign midx = msum[8:1];
   assign lo_next = lo_ff + 8'd1;
   assign e_mid = {CAL_ROM[midx], 8'd0};
   assign e_lo = {CAL_ROM[lo_ff], 8'd0};
   assign e_hi = {CAL_ROM[lo_next], 8'd0};
   assign e_first = {CAL_ROM[0], 8'd0};
   assign e_last = {CAL_ROM[TABLE_ENTRIES-1], 8'd0};
   assign num_diff = s_ff - S_W'(e_lo);
   assign deg = 9'(TOP_TEMP_C) - {1'b0, lo_ff};
   assign old_flag = ram_rdata[RAM_W-1:TEMP_W];
   assign temp_ext = {{(SUM_W-TEMP_W){temp_ff[TEMP_W-1]}}, temp_ff};
   assign old_ext = {{(SUM_W-TEMP_W){ram_rdata[TEMP_W-1]}}, ram_rdata[TEMP_W-1:0]};
   assign abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mstat = {cold_ff != '0, hot_ff != '0};

   // Next state and datapath
   always_comb begin
      state_in = state_ff;
      mid_in = mid_ff;
      prod_in = prod_ff;
      s_in = s_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      flag_in = flag_ff;
      temp_in = temp_ff;
      fill_in = fill_ff;
      slot_in = slot_ff;
      hot_in = hot_ff;
      cold_in = cold_ff;
      primed_in = primed_ff;
      sum_in = sum_ff;
      o_stemp_in = o_stemp_ff;
      o_sstat_in = o_sstat_ff;
      o_mtemp_in = o_mtemp_ff;
      o_mstat_in = o_mstat_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      ram_we = 1'b0;
      ram_waddr = slot_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mid_in = 28'(req_tdata[11:0] * ref_ff);
               state_in = S_PROD;
            end
         end
         // Open divider reads very cold, otherwise form the numerator product
         S_PROD: begin
            if (mid_ff >= full) begin
               flag_in = STAT_COLD;
               temp_in = '0;
               state_in = S_WIN;
            end else begin
               prod_in = 48'(top_ff * mid_ff);
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            div_start = 1'b1;
            div_num = {prod_ff, 8'd0};
            div_den = DIV_DEN_W'(full - mid_ff);
            state_in = S_RWAIT;
         end
         // Resistance in Q.8 ohms, scaled by 100 with shift-adds
         S_RWAIT: begin
            if (div_done) begin
               if (div_q[DIV_NUM_W-1:36] != '0) begin
                  flag_in = STAT_COLD;
                  temp_in = '0;
                  state_in = S_WIN;
               end else begin
                  s_in = (S_W'(div_q[35:0]) << 6) + (S_W'(div_q[35:0]) << 5)
                       + (S_W'(div_q[35:0]) << 2);
                  state_in = S_RANGE;
               end
            end
         end
         S_RANGE: begin
            if (s_ff < S_W'(e_first)) begin
               flag_in = STAT_HOT;
               temp_in = '0;
               state_in = S_WIN;
            end else if (s_ff >= S_W'(e_last)) begin
               flag_in = STAT_COLD;
               temp_in = '0;
               state_in = S_WIN;
            end else begin
               lo_in = '0;
               hi_in = 8'(TABLE_ENTRIES - 1);
               state_in = S_SEARCH;
            end
         end
         // Binary search for the last entry not above the resistance
         S_SEARCH: begin
            if (hi_ff - lo_ff == 8'd1) begin
               state_in = S_FDIV;
            end else if (S_W'(e_mid) <= s_ff) begin
               lo_in = midx;
            end else begin
               hi_in = midx;
            end
         end
         S_FDIV: begin
            div_start = 1'b1;
            div_num = DIV_NUM_W'({num_diff[E_W-1:0], {FRAC_BITS{1'b0}}});
            div_den = DIV_DEN_W'(e_hi - e_lo);
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (div_done) begin
               flag_in = STAT_OK;
               temp_in = TEMP_W'({deg, {FRAC_BITS{1'b0}}})
                       - TEMP_W'(div_q[FRAC_BITS-1:0]);
               state_in = S_WIN;
            end
         end
         // First sample fills the window; later ones replace the oldest slot
         S_WIN: begin
            o_stemp_in = temp_ff;
            o_sstat_in = flag_ff;
            if (!primed_ff) begin
               fill_in = '0;
               sum_in = '0;
               hot_in = (flag_ff == STAT_HOT) ? CNT_W'(WINDOW_LENGTH) : '0;
               cold_in = (flag_ff == STAT_COLD) ? CNT_W'(WINDOW_LENGTH) : '0;
               slot_in = '0;
               state_in = S_FILL;
            end else begin
               state_in = S_UPD;
            end
         end
         S_FILL: begin
            ram_we = 1'b1;
            ram_waddr = fill_ff;
            sum_in = sum_ff + temp_ext;
            fill_in = fill_ff + 1'b1;
            if (fill_ff == SLOT_W'(WINDOW_LENGTH - 1)) begin
               primed_in = 1'b1;
               state_in = S_MDIV;
            end
         end
         S_UPD: begin
            ram_we = 1'b1;
            sum_in = sum_ff + temp_ext - old_ext;
            hot_in = hot_ff - CNT_W'(old_flag == STAT_HOT && hot_ff != '0)
                   + CNT_W'(flag_ff == STAT_HOT);
            cold_in = cold_ff - CNT_W'(old_flag == STAT_COLD && cold_ff != '0)
                    + CNT_W'(flag_ff == STAT_COLD);
            slot_in = (slot_ff == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_ff + 1'b1;
            state_in = S_MDIV;
         end
         // Mean of the magnitude, sign restored afterward
         S_MDIV: begin
            o_mstat_in = mstat;
            if (mstat != STAT_OK) begin
               o_mtemp_in = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_num = DIV_NUM_W'(abs_sum);
               div_den = DIV_DEN_W'(WINDOW_LENGTH);
               state_in = S_MWAIT;
            end
         end
         S_MWAIT: begin
            if (div_done) begin
               o_mtemp_in = sum_ff[SUM_W-1] ? TEMP_W'(-div_q[TEMP_W-1:0])
                                            : div_q[TEMP_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff <= '0;
         hot_ff <= '0;
         cold_ff <= '0;
         primed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         hot_ff <= hot_in;
         cold_ff <= cold_in;
         primed_ff <= primed_in;
      end
      mid_ff <= mid_in;
      prod_ff <= prod_in;
      s_ff <= s_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      flag_ff <= flag_in;
      temp_ff <= temp_in;
      fill_ff <= fill_in;
      sum_ff <= sum_in;
      o_stemp_ff <= o_stemp_in;
      o_sstat_ff <= o_sstat_in;
      o_mtemp_ff <= o_mtemp_in;
      o_mstat_ff <= o_mstat_in;
   end

   tta_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Window slots: {flag, temp}
   tta_ram #(
      .WIDTH  (RAM_W),
      .DEPTH  (WINDOW_LENGTH),
      .ADDR_W (SLOT_W)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({flag_ff, temp_ff}),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tdata = {o_mtemp_ff, o_stemp_ff};
   assign rsp_tuser = {o_mstat_ff, o_sstat_ff};

endmodule

[src/tta_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tta_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 60,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tta_serial_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tta_pkg for operand widths.
module tta_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tta_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [tta_pkg::DIV_DEN_W-1:0] divisor,
   output logic                          done,
   output logic [tta_pkg::DIV_NUM_W-1:0] quotient
);
   import tta_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;

   // One shift-subtract step per cycle; dividend bits shift out as quotient bits shift in
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

[test/tb_thermistor_temperature_averager.sv]
// Self-checking testbench for thermistor_temperature_averager: converter codes in,
// sample and window-mean temperatures out, checked against an in-bench predictor.
// Depends on tta_pkg (status codes, register indexes, calibration table) and the RTL.
module tb_thermistor_temperature_averager;
   timeunit 1ns;
   timeprecision 1ps;
   import tta_pkg::*;

   localparam int WIN_LEN = 60;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic signed [15:0] sample_temp;
      logic [1:0]         sample_status;
      logic signed [15:0] mean_temp;
      logic [1:0]         mean_status;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   // Predictor state: register shadow and window copy
   logic [15:0] ref_mv_q;
   logic [15:0] supply_mv_q;
   logic [19:0] top_ohms_q;
   int          win_temp [WIN_LEN];
   logic [1:0]  win_flag [WIN_LEN];
   int          slot_ptr;
   int          hot_count;
   int          cold_count;
   bit          window_filled;

   logic [15:0] pending_codes [$];
   reading_type expected_readings [$];

   bit          idle_on;
   bit          req_fire;
   int          gap_left;
   int          stall_left;
   int          quiet_cycles;
   int          errors;
   int          words_sent;
   int          words_checked;
   int          hot_seen;
   int          cold_seen;
   int          mean_valid_seen;

   thermistor_temperature_averager i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Resistance from code, table search, linear interpolation
   function automatic void code_to_temp(input logic [11:0] code,
                                        output logic signed [15:0] temp,
                                        output logic [1:0] status);
      longint unsigned mid, full, ohms_q8, scaled, num, den, frac;
      int idx;
      temp = '0;
      mid = 64'(code) * 64'(ref_mv_q);
      full = 64'd4096 * 64'(supply_mv_q);
      if (mid >= full) begin
         status = STAT_COLD;
         return;
      end
      ohms_q8 = ((64'(top_ohms_q) * mid) << 8) / (full - mid);
      scaled = ohms_q8 * 100;
      if (scaled < 64'(CAL_ROM[0]) * 256) begin
         status = STAT_HOT;
         return;
      end
      if (scaled >= 64'(CAL_ROM[TABLE_ENTRIES-1]) * 256) begin
         status = STAT_COLD;
         return;
      end
      idx = 0;
      while (idx + 2 < TABLE_ENTRIES && 64'(CAL_ROM[idx+1]) * 256 <= scaled)
         idx++;
      num = scaled - 64'(CAL_ROM[idx]) * 256;
      den = (64'(CAL_ROM[idx+1]) - 64'(CAL_ROM[idx])) * 256;
      frac = (den != 0) ? ((num << FRAC_BITS) / den) : 0;
      temp = 16'((TOP_TEMP_C - idx) * (1 << FRAC_BITS) - int'(frac));
      status = STAT_OK;
   endfunction

   // Window update and mean for one accepted word
   function automatic reading_type predict_reading(input logic [11:0] code);
      reading_type rd;
      logic signed [15:0] t;
      logic [1:0] st;
      int sum;
      code_to_temp(code, t, st);
      if (!window_filled) begin
         for (int k = 0; k < WIN_LEN; k++) begin
            win_temp[k] = t;
            win_flag[k] = st;
         end
         hot_count = (st == STAT_HOT) ? WIN_LEN : 0;
         cold_count = (st == STAT_COLD) ? WIN_LEN : 0;
         slot_ptr = 0;
         window_filled = 1'b1;
      end else begin
         if (win_flag[slot_ptr] == STAT_HOT && hot_count > 0) hot_count--;
         if (win_flag[slot_ptr] == STAT_COLD && cold_count > 0) cold_count--;
         win_temp[slot_ptr] = t;
         win_flag[slot_ptr] = st;
         if (st == STAT_HOT) hot_count++;
         if (st == STAT_COLD) cold_count++;
         slot_ptr = (slot_ptr + 1 >= WIN_LEN) ? 0 : slot_ptr + 1;
      end
      rd.sample_temp = t;
      rd.sample_status = st;
      rd.mean_status = {cold_count != 0, hot_count != 0};
      rd.mean_temp = '0;
      if (rd.mean_status == 2'd0) begin
         sum = 0;
         for (int k = 0; k < WIN_LEN; k++) sum += win_temp[k];
         rd.mean_temp = 16'(sum / WIN_LEN);
      end
      return rd;
   endfunction

   // Register write while idle; mirror applies the same width masking
   task automatic write_reg(input logic [1:0] index, input logic [19:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_REFERENCE: ref_mv_q = value[15:0];
         CSR_SUPPLY:    supply_mv_q = value[15:0];
         CSR_TOP:       top_ohms_q = value;
         default: ;
      endcase
   endtask

   task automatic set_divider(input logic [19:0] ref_mv, input logic [19:0] sup_mv,
                              input logic [19:0] top);
      write_reg(CSR_REFERENCE, ref_mv);
      write_reg(CSR_SUPPLY, sup_mv);
      write_reg(CSR_TOP, top);
   endtask

   task automatic drain();
      wait (pending_codes.size() == 0 && !req_tvalid);
      wait (expected_readings.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   // Codes spread over the whole range; upper word bits are junk
   task automatic queue_random(input int count);
      for (int n = 0; n < count; n++)
         pending_codes.push_back(16'($urandom));
   endtask

   // Mostly in-table codes for the default divider, rare excursions
   task automatic queue_in_range(input int count);
      logic [11:0] code;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 149) == 0) code = 12'($urandom_range(0, 160));
         else code = 12'($urandom_range(170, 4095));
         pending_codes.push_back({4'($urandom), code});
      end
   endtask

   // Sender: one word at a time, random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else if (req_tvalid && !req_fire) begin
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         gap_left <= $urandom_range(0, 18);
         req_tvalid <= 1'b0;
      end else if (pending_codes.size() > 0) begin
         req_tdata <= pending_codes.pop_front();
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: random back-pressure bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on accepted words, check result words, watchdog
   always @(posedge clock) begin
      reading_type exp_rd;
      bit bad;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         expected_readings.push_back(predict_reading(req_tdata[11:0]));
         words_sent++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result word tdata=%h tuser=%h",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_rd = expected_readings.pop_front();
            bad = 1'b0;
            if (rsp_tdata[15:0] !== exp_rd.sample_temp) begin
               $display("%0t: sample_temp expected %0d got %0d", $time,
                        exp_rd.sample_temp, $signed(rsp_tdata[15:0]));
               bad = 1'b1;
            end
            if (rsp_tuser[1:0] !== exp_rd.sample_status) begin
               $display("%0t: sample_status expected %0d got %0d", $time,
                        exp_rd.sample_status, rsp_tuser[1:0]);
               bad = 1'b1;
            end
            if (rsp_tdata[31:16] !== exp_rd.mean_temp) begin
               $display("%0t: mean_temp expected %0d got %0d", $time,
                        exp_rd.mean_temp, $signed(rsp_tdata[31:16]));
               bad = 1'b1;
            end
            if (rsp_tuser[3:2] !== exp_rd.mean_status) begin
               $display("%0t: mean_status expected %0d got %0d", $time,
                        exp_rd.mean_status, rsp_tuser[3:2]);
               bad = 1'b1;
            end
            if (bad) errors++;
            words_checked++;
            if (exp_rd.sample_status == STAT_HOT) hot_seen++;
            if (exp_rd.sample_status == STAT_COLD) cold_seen++;
            if (exp_rd.mean_status == 2'd0) mean_valid_seen++;
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  expected_readings.size());
         $display("tb_thermistor_temperature_averager: FAIL");
         $finish;
      end
   end

   // Stimulus phases
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_on = 1'b1;
      req_fire = 1'b0;
      gap_left = 0;
      stall_left = 0;
      quiet_cycles = 0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      hot_seen = 0;
      cold_seen = 0;
      mean_valid_seen = 0;
      ref_mv_q = 16'd3300;
      supply_mv_q = 16'd5000;
      top_ohms_q = 20'd10000;
      window_filled = 1'b0;
      slot_ptr = 0;
      hot_count = 0;
      cold_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed at reset values: first word primes the window, then extremes
      pending_codes.push_back(16'd1000);
      pending_codes.push_back(16'd0);
      pending_codes.push_back(16'd4095);
      pending_codes.push_back(16'd1);
      pending_codes.push_back(16'd160);
      pending_codes.push_back(16'd161);
      pending_codes.push_back(16'd2048);
      pending_codes.push_back(16'hF7FF);
      pending_codes.push_back(16'h0800);
      drain();

      // Open divider, zero supply, zero reference, zero resistor
      set_divider(20'd65535, 20'd1, 20'd10000);
      pending_codes.push_back(16'd4095);
      pending_codes.push_back(16'd1);
      drain();
      set_divider(20'hF0000, 20'd0, 20'd10000);
      pending_codes.push_back(16'd0);
      pending_codes.push_back(16'd3000);
      drain();
      set_divider(20'd3300, 20'd5000, 20'd0);
      pending_codes.push_back(16'd2000);
      pending_codes.push_back(16'd4095);
      drain();
      // Masked upper bits and an unused index
      write_reg(CSR_TOP, 20'd1000000);
      write_reg(CSR_REFERENCE, 20'hF0CE4);
      write_reg(2'd3, 20'hFFFFF);
      pending_codes.push_back(16'd3900);
      pending_codes.push_back(16'd4095);
      pending_codes.push_back(16'd100);
      drain();

      // Register extremes
      set_divider(20'd65535, 20'd65535, 20'd1000000);
      queue_random(50);
      drain();
      set_divider(20'd1, 20'd1, 20'd1);
      queue_random(30);
      drain();
      set_divider(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      queue_random(30);
      drain();
      // Random register settings
      for (int p = 0; p < 6; p++) begin
         set_divider(20'($urandom), 20'($urandom), 20'($urandom));
         queue_random(30);
         drain();
      end

      // Long run at reset values so the mean becomes valid; sender pauses midway
      set_divider(20'd3300, 20'd5000, 20'd10000);
      queue_in_range(260);
      drain();
      queue_in_range(220);
      wait (pending_codes.size() == 0);
      idle_on = 1'b0;
      queue_in_range(100);
      drain();

      repeat (250) @(posedge clock);
      $display("Checked %0d results from %0d words over 15 register settings.",
               words_checked, words_sent);
      $display("Samples very hot %0d, very cold %0d; valid window means %0d.",
               hot_seen, cold_seen, mean_valid_seen);
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("tb_thermistor_temperature_averager: PASS");
      end else begin
         $display("tb_thermistor_temperature_averager: FAIL");
      end
      $finish;
   end

endmodule
